// ===== design/bfi_pkg.sv =====
package bfi_pkg;

	localparam int FILTER_BITS = 32;
	localparam int POS_W = $clog2(FILTER_BITS);
	localparam int S_DATA_W = 160;
	localparam int M_DATA_W = 32;

	localparam logic [31:0] HASH_SEED = 32'hdeadbeef;
	localparam logic [31:0] INIT_ITEM = HASH_SEED + 32'd4;
	localparam logic [31:0] INIT_PORT = HASH_SEED + 32'd12;

	localparam logic OP_ITEM = 1'b0;
	localparam logic OP_PORT = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [31:0] item_value;
		logic [63:0] switch_id;
		logic [31:0] port_number;
		logic [31:0] filter_in;
	} key_t;

	typedef struct packed {
		logic [31:0] hash;
		logic [31:0] filter;
	} hashed_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} abc_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int k);
		return (x << k) | (x >> (32 - k));
	endfunction

	// mix round, first three lines
	function automatic abc_t mix_head(input abc_t s);
		abc_t r;
		r = s;
		r.a = r.a - r.c; r.a = r.a ^ rotl(r.c, 4);  r.c = r.c + r.b;
		r.b = r.b - r.a; r.b = r.b ^ rotl(r.a, 6);  r.a = r.a + r.c;
		r.c = r.c - r.b; r.c = r.c ^ rotl(r.b, 8);  r.b = r.b + r.a;
		return r;
	endfunction

	// mix round, last three lines
	function automatic abc_t mix_tail(input abc_t s);
		abc_t r;
		r = s;
		r.a = r.a - r.c; r.a = r.a ^ rotl(r.c, 16); r.c = r.c + r.b;
		r.b = r.b - r.a; r.b = r.b ^ rotl(r.a, 19); r.a = r.a + r.c;
		r.c = r.c - r.b; r.c = r.c ^ rotl(r.b, 4);  r.b = r.b + r.a;
		return r;
	endfunction

	// final avalanche, first four lines
	function automatic abc_t final_head(input abc_t s);
		abc_t r;
		r = s;
		r.c = r.c ^ r.b; r.c = r.c - rotl(r.b, 14);
		r.a = r.a ^ r.c; r.a = r.a - rotl(r.c, 11);
		r.b = r.b ^ r.a; r.b = r.b - rotl(r.a, 25);
		r.c = r.c ^ r.b; r.c = r.c - rotl(r.b, 16);
		return r;
	endfunction

	// final avalanche, last three lines
	function automatic abc_t final_tail(input abc_t s);
		abc_t r;
		r = s;
		r.a = r.a ^ r.c; r.a = r.a - rotl(r.c, 4);
		r.b = r.b ^ r.a; r.b = r.b - rotl(r.a, 14);
		r.c = r.c ^ r.b; r.c = r.c - rotl(r.b, 24);
		return r;
	endfunction

endpackage

// ===== design/bloom_filter_insert.sv =====
// channel  dir  signals                          contents
// s_axis   in   tvalid/tready/tdata[159:0]/tuser  key request and filter word
// m_axis   out  tvalid/tready/tdata[31:0]         updated filter word
//
// Four register stages: initial hash state, first half of the mix or final step,
// second half of it, bit-position set into the output register.
// One request per cycle unless m_axis stalls; each stage advances when it or the
// next one is free. A stall on m_axis backs up stage by stage; nothing is dropped
// or repeated. Reset clears only the valid bits.
module bloom_filter_insert (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// item_value[31:0], switch_id[95:32], port_number[127:96], filter_in[159:128]
	input  logic [bfi_pkg::S_DATA_W-1:0]  s_axis_tdata,
	// opcode
	input  logic                          s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// filter_out[31:0]
	output logic [bfi_pkg::M_DATA_W-1:0]  m_axis_tdata
);
	import bfi_pkg::*;

	key_t        key;
	hashed_t     hashed;
	logic        hash_valid, hash_ready;
	logic        valid_s4;
	logic [FILTER_BITS-1:0] filter_s4;
	logic [POS_W-1:0] p0, p1, p2;
	logic [FILTER_BITS-1:0] set_mask;

	assign key.opcode      = s_axis_tuser;
	assign key.item_value  = s_axis_tdata[31:0];
	assign key.switch_id   = s_axis_tdata[95:32];
	assign key.port_number = s_axis_tdata[127:96];
	assign key.filter_in   = s_axis_tdata[159:128];

	bfi_hash u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_key    (key),
		.out_valid (hash_valid),
		.out_ready (hash_ready),
		.out_hash  (hashed)
	);

	assign p0 = hashed.hash[POS_W-1:0];
	assign p1 = hashed.hash[POS_W-1:0] + hashed.hash[16 +: POS_W];
	assign p2 = hashed.hash[POS_W-1:0] + {hashed.hash[16 +: POS_W-1], 1'b0};
	assign set_mask = (FILTER_BITS'(1) << p0) | (FILTER_BITS'(1) << p1)
		| (FILTER_BITS'(1) << p2);

	assign hash_ready = !valid_s4 || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (hash_ready) begin
			valid_s4 <= hash_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (hash_ready && hash_valid) begin
			filter_s4 <= hashed.filter | set_mask;
		end
	end

	assign m_axis_tvalid = valid_s4;
	assign m_axis_tdata  = filter_s4;

	a_nonzero_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $countones(m_axis_tdata) >= 1)
		else $error("filter word has no bit set");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !hash_valid |=> !m_axis_tvalid)
		else $error("result repeated after it was taken");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> hash_ready)
		else $error("empty output stage does not take a hash");

endmodule

// ===== design/bfi_hash.sv =====
module bfi_hash (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bfi_pkg::key_t  in_key,
	output logic           out_valid,
	input  logic           out_ready,
	output bfi_pkg::hashed_t out_hash
);
	import bfi_pkg::*;

	logic  valid_s1, valid_s2, valid_s3;
	logic  ready_s1, ready_s2, ready_s3;
	logic  op_s1, op_s2;
	abc_t  abc_s1, abc_s2;
	logic [31:0] filter_s1, filter_s2, filter_s3;
	logic [31:0] hash_s3;
	abc_t  init_abc, head_abc, tail_abc;

	assign ready_s3 = !valid_s3 || out_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_comb begin
		if (in_key.opcode == OP_PORT) begin
			init_abc.a = INIT_PORT + in_key.switch_id[31:0];
			init_abc.b = INIT_PORT + in_key.switch_id[63:32];
			init_abc.c = INIT_PORT + in_key.port_number;
		end else begin
			init_abc.a = INIT_ITEM + in_key.item_value;
			init_abc.b = INIT_ITEM;
			init_abc.c = INIT_ITEM;
		end
	end

	assign head_abc = (op_s1 == OP_PORT) ? mix_head(abc_s1) : final_head(abc_s1);
	assign tail_abc = (op_s2 == OP_PORT) ? mix_tail(abc_s2) : final_tail(abc_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			op_s1     <= in_key.opcode;
			abc_s1    <= init_abc;
			filter_s1 <= in_key.filter_in;
		end
		if (ready_s2 && valid_s1) begin
			op_s2     <= op_s1;
			abc_s2    <= head_abc;
			filter_s2 <= filter_s1;
		end
		if (ready_s3 && valid_s2) begin
			hash_s3   <= tail_abc.c;
			filter_s3 <= filter_s2;
		end
	end

	assign out_valid       = valid_s3;
	assign out_hash.hash   = hash_s3;
	assign out_hash.filter = filter_s3;

	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("hash pipeline refuses a request with an empty first stage");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted request missing from first stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !out_ready |=> valid_s3 && $stable(hash_s3))
		else $error("stalled hash dropped or changed");

endmodule

// ===== tb/bloom_filter_insert_tb.sv =====
module bloom_filter_insert_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bfi_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 8;

	class filter_scoreboard;
		logic [31:0] filter_q[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function logic [31:0] rol(logic [31:0] x, int k);
			return (x << k) | (x >> (32 - k));
		endfunction

		function logic [31:0] item_hash(logic [31:0] item);
			logic [31:0] a, b, c;
			a = HASH_SEED + 32'd4;
			b = a;
			c = a;
			a = a + item;
			c = c ^ b; c = c - rol(b, 14);
			a = a ^ c; a = a - rol(c, 11);
			b = b ^ a; b = b - rol(a, 25);
			c = c ^ b; c = c - rol(b, 16);
			a = a ^ c; a = a - rol(c, 4);
			b = b ^ a; b = b - rol(a, 14);
			c = c ^ b; c = c - rol(b, 24);
			return c;
		endfunction

		function logic [31:0] port_hash(logic [63:0] id, logic [31:0] port);
			logic [31:0] a, b, c;
			a = HASH_SEED + 32'd12 + id[31:0];
			b = HASH_SEED + 32'd12 + id[63:32];
			c = HASH_SEED + 32'd12 + port;
			a = a - c; a = a ^ rol(c, 4);  c = c + b;
			b = b - a; b = b ^ rol(a, 6);  a = a + c;
			c = c - b; c = c ^ rol(b, 8);  b = b + a;
			a = a - c; a = a ^ rol(c, 16); c = c + b;
			b = b - a; b = b ^ rol(a, 19); a = a + c;
			c = c - b; c = c ^ rol(b, 4);  b = b + a;
			return c;
		endfunction

		function logic [31:0] key_hash(logic op, logic [31:0] item, logic [63:0] id,
				logic [31:0] port);
			if (op == OP_PORT) begin
				return port_hash(id, port);
			end
			return item_hash(item);
		endfunction

		// positions lo, lo+hi, lo+2*hi, all mod 32
		function logic [31:0] insert_bits(logic [31:0] filter, logic [31:0] h);
			logic [4:0] p0, p1, p2;
			p0 = h[4:0];
			p1 = h[4:0] + h[20:16];
			p2 = h[4:0] + {h[19:16], 1'b0};
			return filter | (32'd1 << p0) | (32'd1 << p1) | (32'd1 << p2);
		endfunction

		function void note_request(logic op, logic [31:0] item, logic [63:0] id,
				logic [31:0] port, logic [31:0] filter);
			filter_q.push_back(insert_bits(filter, key_hash(op, item, id, port)));
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [31:0] got);
			logic [31:0] want;
			if (filter_q.size() == 0) begin
				report($sformatf("unexpected filter_out %h", got));
				return;
			end
			want = filter_q.pop_front();
			if (got !== want)
				report($sformatf("filter_out %h, expected %h", got, want));
		endtask

		function int pending();
			return filter_q.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata;
	logic                s_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [M_DATA_W-1:0] m_axis_tdata;

	filter_scoreboard sb = new();
	int gap_mode;
	int stall_mode;
	int cycles;

	bloom_filter_insert dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("bloom_filter_insert test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// result side backpressure
	initial begin
		int hold;
		int r;
		hold = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			r = $urandom_range(0, 99);
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else if (stall_mode == 0) begin
				m_axis_tready <= 1'b1;
			end else if (r < (stall_mode == 2 ? 45 : 15)) begin
				hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
						$urandom_range(0, 2);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (gap_mode == 0 || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task send_request(input logic op, input logic [31:0] item, input logic [63:0] id,
			input logic [31:0] port, input logic [31:0] filter);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= {$urandom, $urandom, $urandom, $urandom, $urandom};
			s_axis_tuser <= 1'($urandom_range(0, 1));
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {filter, port, id, item};
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(op, item, id, port, filter);
	endtask

	task wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// hi mod 32 of 0 makes all three positions equal, 16 makes lo and lo+2*hi equal
	task send_collision(input logic op, input logic [4:0] hi_mod);
		logic [31:0] item, port;
		logic [63:0] id;
		do begin
			item = $urandom;
			id = {$urandom, $urandom};
			port = $urandom;
		end while (sb.key_hash(op, item, id, port) >> 16 & 32'h1f ^ hi_mod);
		send_request(op, item, id, port, $urandom);
	endtask

	task send_random();
		logic [31:0] filter;
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: filter = '0;
			1: filter = '1;
			2: filter = 32'd1 << $urandom_range(0, 31);
			default: filter = $urandom;
		endcase
		send_request(1'($urandom_range(0, 1)), $urandom, {$urandom, $urandom}, $urandom,
			filter);
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_ITEM;
		gap_mode = 0;
		stall_mode = 0;
		cycles = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		send_request(OP_ITEM, 32'h0, 64'h0, 32'h0, 32'h0);
		send_request(OP_ITEM, '1, '1, '1, '1);
		send_request(OP_ITEM, 32'h0, '1, '1, '1);
		send_request(OP_ITEM, '1, 64'h0, 32'h0, 32'h0);
		send_request(OP_PORT, 32'h0, 64'h0, 32'h0, 32'h0);
		send_request(OP_PORT, '1, '1, '1, 32'h0);
		send_request(OP_PORT, 32'h0, '1, 32'h0, 32'haaaaaaaa);
		send_request(OP_PORT, '1, 64'h0, '1, 32'h55555555);
		send_request(OP_PORT, 32'h0, 64'hffffffff_00000000, 32'h0, '1);
		send_request(OP_PORT, 32'h0, 64'h00000000_ffffffff, 32'h1, 32'h0);
		send_request(OP_ITEM, 32'h1, '1, '1, 32'h0);
		send_request(OP_ITEM, 32'h80000000, {$urandom, $urandom}, $urandom, 32'h0);
		send_request(OP_PORT, $urandom, {$urandom, $urandom}, $urandom, 32'h0);
		send_collision(OP_ITEM, 5'd0);
		send_collision(OP_ITEM, 5'd16);
		send_collision(OP_PORT, 5'd0);
		send_collision(OP_PORT, 5'd16);
		wait_drained();

		repeat (400) send_random();
		gap_mode = 1;
		stall_mode = 1;
		repeat (700) send_random();
		wait_drained();
		stall_mode = 2;
		repeat (400) send_random();
		gap_mode = 0;
		stall_mode = 1;
		repeat (250) send_random();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("bloom_filter_insert test passed");
		end else begin
			$display("bloom_filter_insert test failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/bfi_pkg.sv
design/bfi_hash.sv
design/bloom_filter_insert.sv
tb/bloom_filter_insert_tb.sv
